>>> rtl/assert_macros.svh
// Assertion macros shared by the converter RTL.
// Depends on nothing; simulation builds get checks, SYNTH builds get empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Property check sampled on the rising clock edge, off while reset is low.
`define B2I_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Condition that must never be seen on a clock edge outside reset.
`define B2I_NEVER(label, clk, rst_n, cond, msg) \
    `B2I_ASSERT(label, clk, rst_n, !(cond), msg)
`else
`define B2I_ASSERT(label, clk, rst_n, prop, msg)
`define B2I_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

>>> rtl/b2i_pkg.sv
// Shared types and constants for the BGRA to I420 converter.
// Used by b2i_color_math and bgra_to_i420_converter; depends on nothing.
package b2i_pkg;

    // Frame limits and derived counter widths.
    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);

    // Field widths fixed by the interface.
    localparam int PIX_W        = 8;
    localparam int SIZE_W       = 13;
    localparam int LUMA_IDX_W   = 24;
    localparam int CHROMA_IDX_W = 22;
    localparam int CFG_IDX_W    = 2;

    // Register sizes after reset.
    localparam logic [SIZE_W-1:0] RESET_WIDTH  = SIZE_W'(640);
    localparam logic [SIZE_W-1:0] RESET_HEIGHT = SIZE_W'(480);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = CFG_IDX_W'(1);

    // Luma weights (unsigned, sum scaled by 256).
    localparam int LUMA_SUM_W = 16;
    localparam logic [LUMA_SUM_W-1:0] COEF_YR = 16'd77;
    localparam logic [LUMA_SUM_W-1:0] COEF_YG = 16'd150;
    localparam logic [LUMA_SUM_W-1:0] COEF_YB = 16'd29;

    // Chroma weights (signed) and the bias that folds the +128 offset into the floor shift.
    localparam int CHROMA_SUM_W = 18;
    localparam logic signed [CHROMA_SUM_W-1:0] COEF_UR    = -18'sd43;
    localparam logic signed [CHROMA_SUM_W-1:0] COEF_UG    = -18'sd85;
    localparam logic signed [CHROMA_SUM_W-1:0] COEF_UB    =  18'sd128;
    localparam logic signed [CHROMA_SUM_W-1:0] COEF_VR    =  18'sd128;
    localparam logic signed [CHROMA_SUM_W-1:0] COEF_VG    = -18'sd107;
    localparam logic signed [CHROMA_SUM_W-1:0] COEF_VB    = -18'sd21;
    localparam logic signed [CHROMA_SUM_W-1:0] CHROMA_BIAS = 18'sd32768;

    // One pixel without alpha.
    typedef struct packed {
        logic [PIX_W-1:0] blue;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] red;
    } t_rgb;

    // Converted samples of one pixel.
    typedef struct packed {
        logic [PIX_W-1:0] luma;
        logic [PIX_W-1:0] u;
        logic [PIX_W-1:0] v;
    } t_yuv;

endpackage

>>> rtl/b2i_color_math.sv
// Color conversion of one pixel: full range luma plus point-sampled U and V.
// Depends on b2i_pkg for the weights and the pixel types.
module b2i_color_math (
    input  b2i_pkg::t_rgb i_rgb,
    input  logic          i_chroma_en,
    output b2i_pkg::t_yuv o_yuv
);

    logic [b2i_pkg::LUMA_SUM_W-1:0]          y_sum;
    logic signed [b2i_pkg::CHROMA_SUM_W-1:0] r_s;
    logic signed [b2i_pkg::CHROMA_SUM_W-1:0] g_s;
    logic signed [b2i_pkg::CHROMA_SUM_W-1:0] b_s;
    logic signed [b2i_pkg::CHROMA_SUM_W-1:0] u_sum;
    logic signed [b2i_pkg::CHROMA_SUM_W-1:0] v_sum;

    // Luma: weighted sum fits 16 bits, the top byte is the sample.
    assign y_sum = b2i_pkg::COEF_YR * b2i_pkg::LUMA_SUM_W'(i_rgb.red)
                 + b2i_pkg::COEF_YG * b2i_pkg::LUMA_SUM_W'(i_rgb.green)
                 + b2i_pkg::COEF_YB * b2i_pkg::LUMA_SUM_W'(i_rgb.blue);

    // Zero-extended color components as signed operands.
    assign r_s = signed'(b2i_pkg::CHROMA_SUM_W'(i_rgb.red));
    assign g_s = signed'(b2i_pkg::CHROMA_SUM_W'(i_rgb.green));
    assign b_s = signed'(b2i_pkg::CHROMA_SUM_W'(i_rgb.blue));

    // Chroma: adding 128*256 before the shift gives floor(x/256)+128, always 0..255.
    assign u_sum = b2i_pkg::COEF_UR * r_s + b2i_pkg::COEF_UG * g_s
                 + b2i_pkg::COEF_UB * b_s + b2i_pkg::CHROMA_BIAS;
    assign v_sum = b2i_pkg::COEF_VR * r_s + b2i_pkg::COEF_VG * g_s
                 + b2i_pkg::COEF_VB * b_s + b2i_pkg::CHROMA_BIAS;

    // Chroma samples read as zero on pixels that carry no chroma.
    always_comb begin
        o_yuv.luma = y_sum[15:8];
        if (i_chroma_en) begin
            o_yuv.u = u_sum[15:8];
            o_yuv.v = v_sum[15:8];
        end else begin
            o_yuv.u = '0;
            o_yuv.v = '0;
        end
    end

endmodule

>>> rtl/bgra_to_i420_converter.sv
// BGRA to I420 pixel converter: top level with frame counters and the two-stage pipeline.
// Depends on b2i_pkg, b2i_color_math and assert_macros.svh.

// The block takes one BGRA pixel per cycle in raster order while the output is not stalled
// and returns one result beat per pixel. The beat passes through the input register and the
// result register and is taken when the output is not stalled. Row and column counters
// advance on every accepted beat and wrap at the configured frame size (a size of 0 acts as
// 1, a size above 4096 acts as 4096); frame_end marks the last pixel of a frame. The plane
// indexes are formed by two multiplies ahead of the input register, and the color weights are
// applied between the input register and the result register, so a stalled output holds
// at most two pixels inside. Write frame_width and frame_height only while no beat is in
// flight; a write does not reset the counters.
module bgra_to_i420_converter (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Configuration write port.
    input  logic                                i_cfg_we,
    input  logic [b2i_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [b2i_pkg::SIZE_W-1:0]          i_cfg_data,
    // Pixel input channel.
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [b2i_pkg::PIX_W-1:0]           i_blue,
    input  logic [b2i_pkg::PIX_W-1:0]           i_green,
    input  logic [b2i_pkg::PIX_W-1:0]           i_red,
    // Result output channel.
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [b2i_pkg::PIX_W-1:0]           o_luma,
    output logic [b2i_pkg::LUMA_IDX_W-1:0]      o_luma_index,
    output logic                                o_chroma_valid,
    output logic [b2i_pkg::PIX_W-1:0]           o_chroma_u,
    output logic [b2i_pkg::PIX_W-1:0]           o_chroma_v,
    output logic [b2i_pkg::CHROMA_IDX_W-1:0]    o_chroma_index,
    output logic                                o_frame_end
);

    `include "assert_macros.svh"

    localparam int COL_W = b2i_pkg::COL_W;
    localparam int ROW_W = b2i_pkg::ROW_W;
    localparam int SW    = b2i_pkg::SIZE_W;
    localparam int LW    = b2i_pkg::LUMA_IDX_W;
    localparam int CW    = b2i_pkg::CHROMA_IDX_W;

    // Configuration and counter state.
    logic [SW-1:0]    r_frame_width;
    logic [SW-1:0]    r_frame_height;
    logic [COL_W-1:0] r_col;
    logic [ROW_W-1:0] r_row;
    logic [COL_W-1:0] n_col;
    logic [ROW_W-1:0] n_row;

    // Input stage.
    logic             r_s1_valid;
    b2i_pkg::t_rgb    r_s1_rgb;
    logic [LW-1:0]    r_s1_luma_idx;
    logic [CW-1:0]    r_s1_chroma_idx;
    logic             r_s1_cv;
    logic             r_s1_frame_end;

    // Result stage.
    logic             r_out_valid;
    b2i_pkg::t_yuv    r_out_yuv;
    logic [LW-1:0]    r_out_luma_idx;
    logic [CW-1:0]    r_out_chroma_idx;
    logic             r_out_cv;
    logic             r_out_frame_end;

    logic             in_accept;
    logic             out_adv;
    logic [SW-1:0]    w_eff;
    logic [SW-1:0]    h_eff;
    logic             last_col;
    logic             last_row;
    logic             cv;
    logic [LW-1:0]    luma_idx;
    logic [CW-1:0]    chroma_idx;
    b2i_pkg::t_rgb    in_rgb;
    b2i_pkg::t_yuv    yuv;

    // Handshake: the result register frees when empty or taken, the input stage follows it.
    assign out_adv    = !r_out_valid || i_out_ready;
    assign o_in_ready = !r_s1_valid || out_adv;
    assign in_accept  = i_in_valid && o_in_ready;

    // Configuration writes; unknown indexes are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= b2i_pkg::RESET_WIDTH;
            r_frame_height <= b2i_pkg::RESET_HEIGHT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                b2i_pkg::CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data;
                b2i_pkg::CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Effective frame size: zero acts as one, oversize acts as the maximum.
    always_comb begin
        if (r_frame_width == '0) begin
            w_eff = SW'(1);
        end else if (r_frame_width > SW'(b2i_pkg::MAX_WIDTH)) begin
            w_eff = SW'(b2i_pkg::MAX_WIDTH);
        end else begin
            w_eff = r_frame_width;
        end
        if (r_frame_height == '0) begin
            h_eff = SW'(1);
        end else if (r_frame_height > SW'(b2i_pkg::MAX_HEIGHT)) begin
            h_eff = SW'(b2i_pkg::MAX_HEIGHT);
        end else begin
            h_eff = r_frame_height;
        end
    end

    // Wrap tests use one extra bit so a counter at its top value cannot overflow.
    assign last_col = ({1'b0, r_col} + (COL_W+1)'(1)) >= (COL_W+1)'(w_eff);
    assign last_row = ({1'b0, r_row} + (ROW_W+1)'(1)) >= (ROW_W+1)'(h_eff);
    assign cv       = !r_row[0] && !r_col[0];

    // Plane indexes of the pixel about to enter.
    assign luma_idx = LW'(LW'(r_row) * LW'(w_eff) + LW'(r_col));
    always_comb begin
        if (cv) begin
            chroma_idx = CW'(CW'(r_row >> 1) * CW'(w_eff >> 1) + CW'(r_col >> 1));
        end else begin
            chroma_idx = '0;
        end
    end

    // Counter advance on an accepted beat.
    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (in_accept) begin
            if (last_col) begin
                n_col = '0;
                n_row = last_row ? '0 : r_row + ROW_W'(1);
            end else begin
                n_col = r_col + COL_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    assign in_rgb.blue  = i_blue;
    assign in_rgb.green = i_green;
    assign in_rgb.red   = i_red;

    // Input stage register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_rgb        <= in_rgb;
            r_s1_luma_idx   <= luma_idx;
            r_s1_chroma_idx <= chroma_idx;
            r_s1_cv         <= cv;
            r_s1_frame_end  <= last_col && last_row;
        end
    end

    // Color weights between the two registers.
    b2i_color_math u_color (
        .i_rgb       (r_s1_rgb),
        .i_chroma_en (r_s1_cv),
        .o_yuv       (yuv)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_adv) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_adv && r_s1_valid) begin
            r_out_yuv        <= yuv;
            r_out_luma_idx   <= r_s1_luma_idx;
            r_out_chroma_idx <= r_s1_chroma_idx;
            r_out_cv         <= r_s1_cv;
            r_out_frame_end  <= r_s1_frame_end;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_luma         = r_out_yuv.luma;
    assign o_luma_index   = r_out_luma_idx;
    assign o_chroma_valid = r_out_cv;
    assign o_chroma_u     = r_out_yuv.u;
    assign o_chroma_v     = r_out_yuv.v;
    assign o_chroma_index = r_out_chroma_idx;
    assign o_frame_end    = r_out_frame_end;

    // A full input stage that cannot move on keeps its beat.
    `B2I_ASSERT(a_s1_hold, i_clk, i_rst_n, (r_s1_valid && !out_adv) |=> r_s1_valid, "s1 lost")
    // The column counter returns to zero after the last pixel of a row.
    `B2I_ASSERT(a_col_wrap, i_clk, i_rst_n, (in_accept && last_col) |=> (r_col == '0), "no wrap")
    // Chroma sites sit on even rows and columns, so their luma index is even.
    `B2I_NEVER(a_chroma_even, i_clk, i_rst_n, r_out_valid && r_out_cv && r_out_luma_idx[0], "odd")

endmodule
